/* design/ripemd160_hash_engine_unit_assert.svh */
// Assertion macros shared by the RIPEMD-160 engine RTL.
`ifndef RIPEMD160_HASH_ENGINE_UNIT_ASSERT_SVH
`define RIPEMD160_HASH_ENGINE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that a condition holds at every clock edge out of reset.
`define RMD_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: condition");

// Check that a condition implies another in the same cycle.
`define RMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define RMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define RMD_ASSERT(lbl, clk, rst_n, expr)
`define RMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* design/rmd160_pkg.sv */
// Constants, tables and helper functions of the RIPEMD-160 engine.
package rmd160_pkg;

    // Compression schedule
    localparam int unsigned STEP_COUNT = 160;
    localparam logic [7:0]  STEP_LAST  = 8'(STEP_COUNT - 1);
    localparam logic [6:0]  ROUND_LAST = 7'd79;

    // Initial chaining words
    localparam logic [31:0] IV [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};

    // Additive constants per group of sixteen rounds
    localparam logic [31:0] KL [5] = '{
        32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E};
    localparam logic [31:0] KR [5] = '{
        32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000};

    // Message word selection, left and right lines
    localparam logic [3:0] SEL_L [80] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
        4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
        4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
        4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
        4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
        4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
        4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13};
    localparam logic [3:0] SEL_R [80] = '{
        4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
        4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
        4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
        4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
        4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
        4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
        4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
        4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
        4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
        4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11};

    // Rotate amounts, left and right lines
    localparam logic [4:0] ROT_L [80] = '{
        5'd11, 5'd14, 5'd15, 5'd12, 5'd5, 5'd8, 5'd7, 5'd9,
        5'd11, 5'd13, 5'd14, 5'd15, 5'd6, 5'd7, 5'd9, 5'd8,
        5'd7, 5'd6, 5'd8, 5'd13, 5'd11, 5'd9, 5'd7, 5'd15,
        5'd7, 5'd12, 5'd15, 5'd9, 5'd11, 5'd7, 5'd13, 5'd12,
        5'd11, 5'd13, 5'd6, 5'd7, 5'd14, 5'd9, 5'd13, 5'd15,
        5'd14, 5'd8, 5'd13, 5'd6, 5'd5, 5'd12, 5'd7, 5'd5,
        5'd11, 5'd12, 5'd14, 5'd15, 5'd14, 5'd15, 5'd9, 5'd8,
        5'd9, 5'd14, 5'd5, 5'd6, 5'd8, 5'd6, 5'd5, 5'd12,
        5'd9, 5'd15, 5'd5, 5'd11, 5'd6, 5'd8, 5'd13, 5'd12,
        5'd5, 5'd12, 5'd13, 5'd14, 5'd11, 5'd8, 5'd5, 5'd6};
    localparam logic [4:0] ROT_R [80] = '{
        5'd8, 5'd9, 5'd9, 5'd11, 5'd13, 5'd15, 5'd15, 5'd5,
        5'd7, 5'd7, 5'd8, 5'd11, 5'd14, 5'd14, 5'd12, 5'd6,
        5'd9, 5'd13, 5'd15, 5'd7, 5'd12, 5'd8, 5'd9, 5'd11,
        5'd7, 5'd7, 5'd12, 5'd7, 5'd6, 5'd15, 5'd13, 5'd11,
        5'd9, 5'd7, 5'd15, 5'd11, 5'd8, 5'd6, 5'd6, 5'd14,
        5'd12, 5'd13, 5'd5, 5'd14, 5'd13, 5'd13, 5'd7, 5'd5,
        5'd15, 5'd5, 5'd8, 5'd11, 5'd14, 5'd14, 5'd6, 5'd14,
        5'd6, 5'd9, 5'd12, 5'd9, 5'd12, 5'd5, 5'd15, 5'd8,
        5'd8, 5'd5, 5'd12, 5'd9, 5'd12, 5'd5, 5'd14, 5'd6,
        5'd8, 5'd13, 5'd6, 5'd5, 5'd15, 5'd13, 5'd11, 5'd11};

    // Rotate a word left by a variable amount
    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

    // Boolean function of each group
    function automatic logic [31:0] mix(input logic [2:0] g, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z);
        logic [31:0] f;
        unique case (g)
            3'd0:    f = x ^ y ^ z;
            3'd1:    f = (x & y) | (~x & z);
            3'd2:    f = (x | ~y) ^ z;
            3'd3:    f = (x & z) | (y & ~z);
            default: f = x ^ (y | ~z);
        endcase
        return f;
    endfunction

endpackage

/* design/ripemd160_hash_engine_unit.sv */
// RIPEMD-160 hash engine: byte intake, padding, iterative compression, digest output.
//
// Message bytes arrive at most one per slave transaction and are taken at one per cycle
// while the engine is idle. Each full 64-byte block then holds off input while ST_LOAD
// loads the working registers, ST_COMP runs a single shared step unit over the left and
// right lines in turn (one step per cycle, fed by a single-port read of the 16-word
// block store), and ST_FINAL adds the result into the chaining value. A transaction
// with tlast appends the padding one byte per cycle (plus one or two block compressions),
// then offers the five digest words as five master transactions, word 0 first; the
// engine is reinitialized after the fifth is taken.
`include "ripemd160_hash_engine_unit_assert.svh"

module ripemd160_hash_engine_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);
    import rmd160_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_COMP,
        ST_FINAL,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN
    } phase_t;

    state_t      state_reg;
    phase_t      phase_reg;
    logic [60:0] cnt_reg;
    logic [31:0] cv_reg [5];
    logic        pad_active_reg;
    logic        finish_reg;
    logic [7:0]  step_reg;
    logic [2:0]  word_idx_reg;

    logic [63:0] len_reg;
    logic [23:0] buf_reg;
    logic [31:0] blk_mem [16];
    logic [31:0] w_rd_reg;
    logic [31:0] wa_reg [2];
    logic [31:0] wb_reg [2];
    logic [31:0] wc_reg [2];
    logic [31:0] wd_reg [2];
    logic [31:0] we_reg [2];

    logic [5:0]  pos;
    logic        in_acc;
    logic        out_acc;
    logic        pad_len;
    logic [7:0]  pad_byte;
    logic        absorb_en;
    logic [7:0]  absorb_byte;
    logic [60:0] cnt_inc;
    logic [7:0]  step_next;
    logic [6:0]  nround;
    logic [3:0]  rd_addr;
    logic        line;
    logic [6:0]  round;
    logic [2:0]  grp;
    logic [2:0]  fsel;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [4:0]  r_amt;
    logic [31:0] step_sum;
    logic [31:0] step_t;

    // Handshakes and byte position in the block
    assign pos     = cnt_reg[5:0];
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign cnt_inc = cnt_reg + 61'd1;

    // Pick the padding byte: marker, zero fill or bit length
    assign pad_len = (phase_reg == PH_LEN) || ((phase_reg == PH_ZERO) && (pos == 6'd56));
    always_comb
    begin
        if (phase_reg == PH_MARK)
        begin
            pad_byte = 8'h80;
        end
        else if (pad_len)
        begin
            pad_byte = len_reg[{pos[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // Absorb a byte from the input or from the padding sequencer
    assign absorb_en   = ((state_reg == ST_IDLE) && in_acc && s_axis_tuser[0])
                       || (state_reg == ST_PAD);
    assign absorb_byte = (state_reg == ST_PAD) ? pad_byte : s_axis_tdata;

    // Address of the message word for the next step
    assign step_next = step_reg + 8'd1;
    assign nround    = (step_next[7:1] > ROUND_LAST) ? 7'd0 : step_next[7:1];
    always_comb
    begin
        if (state_reg == ST_COMP)
        begin
            rd_addr = step_next[0] ? SEL_R[nround] : SEL_L[nround];
        end
        else
        begin
            rd_addr = SEL_L[0];
        end
    end

    // Shared step unit, left line on even steps and right line on odd steps
    assign line  = step_reg[0];
    assign round = step_reg[7:1];
    assign grp   = round[6:4];
    assign fsel  = line ? 3'(3'd4 - grp) : grp;
    assign f_val = mix(fsel, wb_reg[line], wc_reg[line], wd_reg[line]);
    assign k_val = line ? KR[grp] : KL[grp];
    assign r_amt = line ? ROT_R[round] : ROT_L[round];
    assign step_sum = wa_reg[line] + f_val + w_rd_reg + k_val;
    assign step_t   = rotl(step_sum, r_amt) + we_reg[line];

    // Sequence intake, padding, compression and digest output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_MARK;
            cnt_reg        <= '0;
            pad_active_reg <= 1'b0;
            finish_reg     <= 1'b0;
            step_reg       <= '0;
            word_idx_reg   <= '0;
            for (int i = 0; i < 5; i++)
            begin
                cv_reg[i] <= IV[i];
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (s_axis_tuser[0])
                        begin
                            cnt_reg <= cnt_inc;
                        end
                        pad_active_reg <= s_axis_tlast;
                        phase_reg      <= PH_MARK;
                        if (s_axis_tuser[0] && (pos == 6'd63))
                        begin
                            state_reg <= ST_LOAD;
                        end
                        else if (s_axis_tlast)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    cnt_reg <= cnt_inc;
                    if (phase_reg == PH_MARK)
                    begin
                        phase_reg <= PH_ZERO;
                    end
                    else if (pad_len)
                    begin
                        phase_reg <= PH_LEN;
                    end
                    if (pad_len && (pos == 6'd63))
                    begin
                        finish_reg <= 1'b1;
                    end
                    if (pos == 6'd63)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_COMP;
                end
                ST_COMP:
                begin
                    step_reg <= step_next;
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= ST_FINAL;
                    end
                end
                ST_FINAL:
                begin
                    cv_reg[0] <= cv_reg[1] + wc_reg[0] + wd_reg[1];
                    cv_reg[1] <= cv_reg[2] + wd_reg[0] + we_reg[1];
                    cv_reg[2] <= cv_reg[3] + we_reg[0] + wa_reg[1];
                    cv_reg[3] <= cv_reg[4] + wa_reg[0] + wb_reg[1];
                    cv_reg[4] <= cv_reg[0] + wb_reg[0] + wc_reg[1];
                    priority if (finish_reg)
                    begin
                        word_idx_reg <= '0;
                        state_reg    <= ST_OUT;
                    end
                    else if (pad_active_reg)
                    begin
                        state_reg <= ST_PAD;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT:
                begin
                    if (out_acc)
                    begin
                        if (word_idx_reg == 3'd4)
                        begin
                            for (int i = 0; i < 5; i++)
                            begin
                                cv_reg[i] <= IV[i];
                            end
                            cnt_reg        <= '0;
                            finish_reg     <= 1'b0;
                            pad_active_reg <= 1'b0;
                            phase_reg      <= PH_MARK;
                            state_reg      <= ST_IDLE;
                        end
                        else
                        begin
                            word_idx_reg <= word_idx_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Block store: write a word when its fourth byte arrives, read one word a cycle
    always_ff @(posedge clk)
    begin
        if (absorb_en && (pos[1:0] == 2'd3))
        begin
            blk_mem[pos[5:2]] <= {absorb_byte, buf_reg};
        end
        w_rd_reg <= blk_mem[rd_addr];
    end

    // Hold partial word bytes and the captured bit length
    always_ff @(posedge clk)
    begin
        if (absorb_en && (pos[1:0] != 2'd3))
        begin
            buf_reg[{pos[1:0], 3'b000} +: 8] <= absorb_byte;
        end
        if ((state_reg == ST_IDLE) && in_acc && s_axis_tlast)
        begin
            len_reg <= {(s_axis_tuser[0] ? cnt_inc : cnt_reg), 3'b000};
        end
    end

    // Working registers of both lines
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            for (int i = 0; i < 2; i++)
            begin
                wa_reg[i] <= cv_reg[0];
                wb_reg[i] <= cv_reg[1];
                wc_reg[i] <= cv_reg[2];
                wd_reg[i] <= cv_reg[3];
                we_reg[i] <= cv_reg[4];
            end
        end
        else if (state_reg == ST_COMP)
        begin
            wa_reg[line] <= we_reg[line];
            we_reg[line] <= wd_reg[line];
            wd_reg[line] <= rotl(wc_reg[line], 5'd10);
            wc_reg[line] <= wb_reg[line];
            wb_reg[line] <= step_t;
        end
    end

    // Drive the stream ports
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = cv_reg[word_idx_reg];
    assign m_axis_tuser  = word_idx_reg;
    assign m_axis_tlast  = (word_idx_reg == 3'd4);

    // Input and output sides never open together
    `RMD_ASSERT(a_ready_valid_excl, clk, rst_n, !(s_axis_tready && m_axis_tvalid))
    // Step counter stays inside the schedule while compressing
    `RMD_ASSERT_IMP(a_step_range, clk, rst_n, state_reg == ST_COMP, step_reg <= STEP_LAST)
    // Digest output only follows a finished padding pass
    `RMD_ASSERT_IMP(a_out_after_finish, clk, rst_n, m_axis_tvalid, finish_reg)
    // Taking the final word reinitializes the engine
    `RMD_ASSERT_NXT(a_reinit, clk, rst_n, out_acc && m_axis_tlast,
                    (cnt_reg == 61'd0) && (cv_reg[0] == IV[0]) && s_axis_tready)

endmodule
